[rtl/ppec_pkg.sv]
// Shared types and constants for the pin pulse event capture block.
package ppec_pkg;

	// Width of the microsecond time base used for pulse measurement (16 to 64).
	localparam int TIME_BITS = 64;

	localparam logic [3:0] PIN_BITS       = 4'hf;
	localparam logic [3:0] EDGE_FALL      = 4'h4;
	localparam logic [3:0] EDGE_RISE      = 4'h8;
	localparam logic [5:0] PULSE_BITS     = 6'h30;
	localparam logic [5:0] LOW_PULSE_BIT  = 6'h10;
	localparam logic [5:0] HIGH_PULSE_BIT = 6'h20;

	typedef enum logic {
		ACT_PIN_EVENT = 1'b0,
		ACT_WAIT      = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_READY = 2'd1,
		STATUS_BAD_SEL   = 2'd2
	} status_t;

endpackage

[rtl/ppec_req_if.sv]
// Request channel: pin events and wait requests.
interface ppec_req_if import ppec_pkg::*; ();
	logic        valid;
	logic        ready;
	action_t     action;
	logic [3:0]  event_bits;
	logic [63:0] timestamp;
	logic [5:0]  wait_selection;

	modport source (output valid, action, event_bits, timestamp, wait_selection, input ready);
	modport sink (input valid, action, event_bits, timestamp, wait_selection, output ready);
endinterface

[rtl/ppec_rsp_if.sv]
// Response channel: one result per request.
interface ppec_rsp_if import ppec_pkg::*; ();
	logic        valid;
	logic        ready;
	status_t     status;
	logic [63:0] pulse_width;
	logic [3:0]  irq_enable;
	logic [5:0]  pending_events;
	logic        notify;

	modport source (output valid, status, pulse_width, irq_enable, pending_events, notify,
		input ready);
	modport sink (input valid, status, pulse_width, irq_enable, pending_events, notify,
		output ready);
endinterface

[rtl/pin_pulse_event_capture_top.sv]
// Pin event latch with low and high pulse-width capture.
//
//   channel  direction  handshake     carries
//   req      in         valid/ready   action, event_bits, timestamp, wait_selection
//   rsp      out        valid/ready   status, pulse_width, irq_enable, pending_events, notify
//
// Each request is taken into an input register, processed against the event
// state combinationally and written to the response register; one request per
// cycle is sustained while the response is not stalled. The compare, subtract
// and latch on the input register set this rate. The input register keeps
// accepting while the response register drains; a stalled response holds the
// request stage, and the request channel stalls only once both are full.
// Reset (arst_n low) clears all event, arming and measurement state.
module pin_pulse_event_capture_top import ppec_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ppec_req_if.sink  req,
	ppec_rsp_if.source rsp
);

	// Request stage.
	logic                 valid_s1;
	action_t              action_s1;
	logic [3:0]           event_bits_s1;
	logic [TIME_BITS-1:0] timestamp_s1;
	logic [5:0]           selection_s1;

	// Event state.
	logic [5:0]           armed_q;
	logic [5:0]           latched_q;
	logic [TIME_BITS-1:0] low_val_q;
	logic                 low_prog_q;
	logic [TIME_BITS-1:0] high_val_q;
	logic                 high_prog_q;

	// Response register.
	logic                 rsp_valid_q;
	status_t              status_q;
	logic [63:0]          width_q;
	logic [3:0]           irq_q;
	logic [5:0]           pending_q;
	logic                 notify_q;

	// Next-state values.
	logic [5:0]           armed_d;
	logic [5:0]           latched_d;
	logic [TIME_BITS-1:0] low_val_d;
	logic                 low_prog_d;
	logic [TIME_BITS-1:0] high_val_d;
	logic                 high_prog_d;
	status_t              status_d;
	logic [TIME_BITS-1:0] width_d;
	logic [3:0]           irq_d;
	logic [5:0]           ev;
	logic [5:0]           sel_minus_one;
	logic                 fall;
	logic                 rise;
	logic                 s1_fire;

	assign s1_fire   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_fire;

	assign fall          = (event_bits_s1 & EDGE_FALL) != 4'h0;
	assign rise          = (event_bits_s1 & EDGE_RISE) != 4'h0;
	assign sel_minus_one = selection_s1 - 6'd1;

	always_comb begin
		armed_d     = armed_q;
		latched_d   = latched_q;
		low_val_d   = low_val_q;
		low_prog_d  = low_prog_q;
		high_val_d  = high_val_q;
		high_prog_d = high_prog_q;
		status_d    = STATUS_OK;
		width_d     = '0;
		ev          = {2'b00, event_bits_s1};

		if (action_s1 == ACT_PIN_EVENT) begin
			// Within one event the start edge is taken before the end edge.
			if ((armed_q & LOW_PULSE_BIT) != 6'h0) begin
				if (fall && !low_prog_d) begin
					low_val_d  = timestamp_s1;
					low_prog_d = 1'b1;
				end
				if (rise && low_prog_d) begin
					low_val_d  = timestamp_s1 - low_val_d;
					low_prog_d = 1'b0;
					ev         = ev | LOW_PULSE_BIT;
				end
			end
			if ((armed_q & HIGH_PULSE_BIT) != 6'h0) begin
				if (rise && !high_prog_d) begin
					high_val_d  = timestamp_s1;
					high_prog_d = 1'b1;
				end
				if (fall && high_prog_d) begin
					high_val_d  = timestamp_s1 - high_val_d;
					high_prog_d = 1'b0;
					ev          = ev | HIGH_PULSE_BIT;
				end
			end
			// Edges only drive the pulse logic while a pulse is armed.
			if ((armed_q & PULSE_BITS) != 6'h0) begin
				ev = ev & ~{2'b00, EDGE_FALL | EDGE_RISE};
			end
			latched_d = latched_q | ev;
			armed_d   = armed_q & ~ev;
		end else if ((selection_s1 & sel_minus_one) != 6'h0) begin
			status_d = STATUS_BAD_SEL;
		end else if ((latched_q & selection_s1) != 6'h0) begin
			latched_d = latched_q & ~selection_s1;
			if ((selection_s1 & LOW_PULSE_BIT) != 6'h0) begin
				width_d = low_val_q;
			end
			if ((selection_s1 & HIGH_PULSE_BIT) != 6'h0) begin
				width_d = high_val_q;
			end
		end else begin
			armed_d  = armed_q | selection_s1;
			status_d = STATUS_NOT_READY;
		end

		irq_d = armed_d[3:0] & PIN_BITS;
		if ((armed_d & PULSE_BITS) != 6'h0) begin
			irq_d = irq_d | EDGE_FALL | EDGE_RISE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1     <= req.action;
			event_bits_s1 <= req.event_bits;
			timestamp_s1  <= req.timestamp[TIME_BITS-1:0];
			selection_s1  <= req.wait_selection;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= '0;
			latched_q   <= '0;
			low_val_q   <= '0;
			low_prog_q  <= 1'b0;
			high_val_q  <= '0;
			high_prog_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				armed_q     <= armed_d;
				latched_q   <= latched_d;
				low_val_q   <= low_val_d;
				low_prog_q  <= low_prog_d;
				high_val_q  <= high_val_d;
				high_prog_q <= high_prog_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q  <= status_d;
			width_q   <= 64'(width_d);
			irq_q     <= irq_d;
			pending_q <= latched_d;
			notify_q  <= (action_s1 == ACT_PIN_EVENT);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.pulse_width    = width_q;
	assign rsp.irq_enable     = irq_q;
	assign rsp.pending_events = pending_q;
	assign rsp.notify         = notify_q;

endmodule

[tb/tb_pin_pulse_event_capture_top.sv]
// Self-checking testbench for the pin pulse event capture block.
module tb_pin_pulse_event_capture_top;
	import ppec_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam logic [63:0] TIME_MASK =
		(TIME_BITS >= 64) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [3:0] BOTH_EDGES = EDGE_FALL | EDGE_RISE;

	typedef struct {
		action_t     act;
		logic [3:0]  ev;
		logic [63:0] ts;
		logic [5:0]  sel;
		bit          drain;
	} pin_req_t;

	typedef struct {
		status_t     status;
		logic [63:0] width;
		logic [3:0]  irq;
		logic [5:0]  pend;
		logic        notify;
	} capture_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppec_req_if req_ch ();
	ppec_rsp_if rsp_ch ();

	pin_pulse_event_capture_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Requests still to be sent, and responses owed by the block in order.
	pin_req_t     event_req_q[$];
	capture_rsp_t capture_rsp_q[$];

	// Predicted event state of the pin.
	logic [5:0]  armed_mask;
	logic [5:0]  latched_events;
	logic [63:0] low_pulse_val;
	logic [63:0] high_pulse_val;
	logic        low_running;
	logic        high_running;

	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	logic req_took = 1'b0;
	logic rsp_took = 1'b0;
	bit   req_busy = 1'b0;
	bit   send_calm = 1'b0;
	bit   recv_calm = 1'b0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;

	function automatic capture_rsp_t apply_pin_request(pin_req_t r);
		capture_rsp_t o;
		logic [5:0]  ev;
		logic [63:0] now;
		logic [5:0]  sel;
		o.status = STATUS_OK;
		o.width  = '0;
		o.notify = 1'b0;
		ev  = {2'b00, r.ev};
		now = r.ts & TIME_MASK;
		sel = r.sel;
		if (r.act == ACT_PIN_EVENT) begin
			// The start edge is handled before the end edge, so both in one event give width 0 when no pulse is running.
			if ((armed_mask & LOW_PULSE_BIT) != '0) begin
				if ((ev[3:0] & EDGE_FALL) != '0 && !low_running) begin
					low_pulse_val = now;
					low_running = 1'b1;
				end
				if ((ev[3:0] & EDGE_RISE) != '0 && low_running) begin
					low_pulse_val = (now - low_pulse_val) & TIME_MASK;
					low_running = 1'b0;
					ev |= LOW_PULSE_BIT;
				end
			end
			if ((armed_mask & HIGH_PULSE_BIT) != '0) begin
				if ((ev[3:0] & EDGE_RISE) != '0 && !high_running) begin
					high_pulse_val = now;
					high_running = 1'b1;
				end
				if ((ev[3:0] & EDGE_FALL) != '0 && high_running) begin
					high_pulse_val = (now - high_pulse_val) & TIME_MASK;
					high_running = 1'b0;
					ev |= HIGH_PULSE_BIT;
				end
			end
			if ((armed_mask & PULSE_BITS) != '0)
				ev &= ~{2'b00, BOTH_EDGES};
			latched_events |= ev;
			armed_mask &= ~ev;
			o.notify = 1'b1;
		end else if ((sel & (sel - 6'd1)) != '0) begin
			o.status = STATUS_BAD_SEL;
		end else if ((latched_events & sel) != '0) begin
			latched_events &= ~sel;
			if ((sel & LOW_PULSE_BIT) != '0)
				o.width = low_pulse_val;
			if ((sel & HIGH_PULSE_BIT) != '0)
				o.width = high_pulse_val;
		end else begin
			armed_mask |= sel;
			o.status = STATUS_NOT_READY;
		end
		o.irq  = armed_mask[3:0] | (((armed_mask & PULSE_BITS) != '0) ? BOTH_EDGES : 4'h0);
		o.pend = latched_events;
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void push_pin(logic [3:0] ev, logic [63:0] ts);
		pin_req_t r;
		r.act   = ACT_PIN_EVENT;
		r.ev    = ev;
		r.ts    = ts;
		r.sel   = 6'($urandom);
		r.drain = 1'b0;
		event_req_q.push_back(r);
	endfunction

	function automatic void push_wait(logic [5:0] sel);
		pin_req_t r;
		r.act   = ACT_WAIT;
		r.ev    = 4'($urandom);
		r.ts    = rand64();
		r.sel   = sel;
		r.drain = 1'b0;
		event_req_q.push_back(r);
	endfunction

	// Mostly short gaps, now and then a long one; none at all while calm.
	function automatic int unsigned draw_gap(bit calm);
		int unsigned p;
		p = $urandom_range(0, 99);
		if (calm || p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Transfers on both channels are taken at the rising edge.
	always @(posedge clk) begin
		capture_rsp_t want;
		if (!arst_n) begin
			req_took <= 1'b0;
			rsp_took <= 1'b0;
		end else begin
			req_took <= req_ch.valid && req_ch.ready;
			rsp_took <= rsp_ch.valid && rsp_ch.ready;
			if (req_ch.valid && req_ch.ready)
				capture_rsp_q.push_back(apply_pin_request(event_req_q[0]));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (capture_rsp_q.size() == 0) begin
					flag_mismatch("response with nothing outstanding", 64'(rsp_ch.status),
						64'd0);
				end else begin
					want = capture_rsp_q.pop_front();
					if (rsp_ch.status !== want.status)
						flag_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
					if (rsp_ch.pulse_width !== want.width)
						flag_mismatch("pulse_width", rsp_ch.pulse_width, want.width);
					if (rsp_ch.irq_enable !== want.irq)
						flag_mismatch("irq_enable", 64'(rsp_ch.irq_enable), 64'(want.irq));
					if (rsp_ch.pending_events !== want.pend)
						flag_mismatch("pending_events", 64'(rsp_ch.pending_events),
							64'(want.pend));
					if (rsp_ch.notify !== want.notify)
						flag_mismatch("notify", 64'(rsp_ch.notify), 64'(want.notify));
				end
			end
		end
	end

	// Request driver and response back-pressure, both moving at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_took) begin
				event_req_q.delete(0);
				req_busy = 1'b0;
				send_gap = draw_gap(send_calm);
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
			end
			if (!req_busy) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (event_req_q.size() != 0 &&
					!(event_req_q[0].drain && capture_rsp_q.size() != 0)) begin
					req_ch.action         <= event_req_q[0].act;
					req_ch.event_bits     <= event_req_q[0].ev;
					req_ch.timestamp      <= event_req_q[0].ts;
					req_ch.wait_selection <= event_req_q[0].sel;
					req_busy = 1'b1;
				end
			end
			req_ch.valid <= req_busy;

			if (rsp_took) begin
				recv_stall = draw_gap(recv_calm);
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
			end
			if (recv_stall != 0) begin
				recv_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned mode;
		int unsigned n_ev;
		bit          lo;
		bit          hi;
		logic [3:0]  pin_ev;
		logic [5:0]  one_bit;
		logic [63:0] t;
		int unsigned spin;

		req_ch.valid          = 1'b0;
		req_ch.action         = ACT_PIN_EVENT;
		req_ch.event_bits     = '0;
		req_ch.timestamp      = '0;
		req_ch.wait_selection = '0;
		rsp_ch.ready          = 1'b0;

		armed_mask     = '0;
		latched_events = '0;
		low_pulse_val  = '0;
		high_pulse_val = '0;
		low_running    = 1'b0;
		high_running   = 1'b0;

		// Directed opening: selection extremes, plain levels and edges, both pulse kinds.
		push_wait(6'h00);
		push_wait(6'h03);
		push_wait(6'h3f);
		push_pin(4'hf, 64'h0);
		push_wait(6'h01);
		push_wait(6'h01);
		push_pin(4'h1, 64'hffff_ffff_ffff_ffff);
		push_wait(LOW_PULSE_BIT);
		push_pin(EDGE_FALL, 64'hffff_ffff_ffff_fff0);
		push_pin(EDGE_RISE, 64'h10);
		push_wait(LOW_PULSE_BIT);
		push_wait(HIGH_PULSE_BIT);
		push_pin(EDGE_RISE, 64'd100);
		push_pin(EDGE_FALL | 4'h1, 64'd350);
		push_wait(HIGH_PULSE_BIT);
		event_req_q[$].drain = 1'b1;
		push_wait(LOW_PULSE_BIT);
		push_wait(HIGH_PULSE_BIT);
		push_pin(BOTH_EDGES, 64'd1000);
		push_wait(LOW_PULSE_BIT);
		push_wait(HIGH_PULSE_BIT);
		push_wait({2'b00, EDGE_RISE});
		push_pin(EDGE_RISE | 4'h2, 64'hffff_ffff_ffff_ffff);
		push_wait({2'b00, EDGE_RISE});
		push_wait({2'b00, EDGE_FALL});
		push_pin(4'h0, 64'h8000_0000_0000_0000);

		while (event_req_q.size() < 25 + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// A pulse measurement: arm, feed alternating edges, then collect.
				mode = $urandom_range(0, 2);
				lo = (mode != 1);
				hi = (mode != 0);
				if (lo)
					push_wait(LOW_PULSE_BIT);
				if (hi)
					push_wait(HIGH_PULSE_BIT);
				t = ($urandom_range(0, 3) == 0) ? {32'hffff_ffff, $urandom} : rand64();
				n_ev = $urandom_range(1, 4);
				for (int j = 0; j < n_ev; j++) begin
					pin_ev = (((j % 2) == 0) == lo) ? EDGE_FALL : EDGE_RISE;
					case ($urandom_range(0, 9))
						0: begin
							pin_ev = 4'($urandom);
						end
						1: begin
							pin_ev = BOTH_EDGES;
						end
						default: begin
							pin_ev |= 4'($urandom_range(0, 3));
						end
					endcase
					push_pin(pin_ev, t);
					t += ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 5000));
				end
				if (lo)
					push_wait(LOW_PULSE_BIT);
				if (hi)
					push_wait(HIGH_PULSE_BIT);
				if ($urandom_range(0, 3) == 0)
					push_wait(6'($urandom));
			end else if (pick < 70) begin
				one_bit = 6'd1 << $urandom_range(0, 3);
				push_wait(one_bit);
				pin_ev = ($urandom_range(0, 3) == 0) ? 4'($urandom) : (one_bit[3:0] | 4'($urandom));
				push_pin(pin_ev, rand64());
				push_wait(one_bit);
			end else begin
				if ($urandom_range(0, 1) == 0)
					push_pin(4'($urandom), rand64());
				else if ($urandom_range(0, 1) == 0)
					push_wait(6'($urandom));
				else
					push_wait(($urandom_range(0, 6) == 6) ? 6'h00 : (6'd1 << $urandom_range(0, 5)));
			end
			if ($urandom_range(0, 119) == 0)
				event_req_q[$].drain = 1'b1;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (event_req_q.size() != 0)
			@(posedge clk);
		spin = 0;
		while (capture_rsp_q.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		while (capture_rsp_q.size() != 0)
			flag_mismatch("response never delivered", 64'd0,
				64'(capture_rsp_q.pop_front().status));

		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
